### sv/keypad_lock_thermostat_top_assert.svh
// Assertion helpers for the RTL of the keypad lock and thermostat block.
`ifndef KEYPAD_LOCK_THERMOSTAT_TOP_ASSERT_SVH
`define KEYPAD_LOCK_THERMOSTAT_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KLT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keypad_lock_thermostat: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define KLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keypad_lock_thermostat: next-cycle check failed");

`endif

### sv/klt_pkg.sv
`default_nettype none
package klt_pkg;

    localparam int MaxEntry    = 16;
    localparam int MaxPassword = 8;

    localparam int ByteW      = 8;
    localparam int CodeW      = 6;
    localparam int PwCodesW   = 48;
    localparam int PwLenW     = 4;
    localparam int DutyW      = 7;
    localparam int PwmW       = 8;
    localparam int AlarmW     = 2;
    localparam int EventW     = 4;
    localparam int CountW     = 5;
    localparam int EntryIdxW  = $clog2(MaxEntry);
    localparam int EntryCntW  = $clog2(MaxEntry + 1);
    localparam int ApbAddrW   = 4;
    localparam int ApbDataW   = 64;

    // Register index taken from the address bit that selects the 8-byte slot.
    localparam int RegIdxBit = 3;
    localparam logic RegCodes  = 1'b0;
    localparam logic RegLength = 1'b1;

    localparam logic [PwCodesW-1:0] PwCodesReset = PwCodesW'(2363969);
    localparam logic [PwLenW-1:0]   PwLenReset   = PwLenW'(4);

    // Event codes reported with each result.
    localparam logic [EventW-1:0] EvIgnored = 4'd0;
    localparam logic [EventW-1:0] EvStored  = 4'd1;
    localparam logic [EventW-1:0] EvFull    = 4'd2;
    localparam logic [EventW-1:0] EvErased  = 4'd3;
    localparam logic [EventW-1:0] EvToggled = 4'd4;
    localparam logic [EventW-1:0] EvGranted = 4'd5;
    localparam logic [EventW-1:0] EvWrong   = 4'd6;
    localparam logic [EventW-1:0] EvTemp    = 4'd7;
    localparam logic [EventW-1:0] EvLight   = 4'd8;

    // Key codes with a meaning of their own.
    localparam logic [CodeW-1:0] KeyEnter  = 6'd10;
    localparam logic [CodeW-1:0] KeyErase  = 6'd11;
    localparam logic [CodeW-1:0] KeyToggle = 6'd12;

    // Alarm codes.
    localparam logic [AlarmW-1:0] AlarmNone = 2'd0;
    localparam logic [AlarmW-1:0] AlarmHot  = 2'd1;
    localparam logic [AlarmW-1:0] AlarmCold = 2'd2;

    // Command byte ranges.
    localparam logic [ByteW-1:0] TempLimit = 8'd100;
    localparam logic [ByteW-1:0] KeyBase   = 8'd200;

    // Temperature bands.
    localparam logic [DutyW-1:0] TempCoolLo = 7'd25;
    localparam logic [DutyW-1:0] TempCoolHi = 7'd55;
    localparam logic [DutyW-1:0] TempHeatLo = 7'd3;
    localparam logic [DutyW-1:0] TempHeatHi = 7'd20;

    localparam logic [DutyW-1:0] CoolBase = 7'd50;
    localparam logic [DutyW-1:0] CoolStep = 7'd10;
    localparam logic [DutyW-1:0] HeatFull = 7'd100;
    localparam logic [DutyW-1:0] HeatStep = 7'd25;

    // Light bands, limits on the light level (byte minus 100).
    localparam logic [ByteW-1:0] LightLvl1 = 8'd25;
    localparam logic [ByteW-1:0] LightLvl2 = 8'd50;
    localparam logic [ByteW-1:0] LightLvl3 = 8'd75;
    localparam logic [DutyW-1:0] LightDuty1 = 7'd100;
    localparam logic [DutyW-1:0] LightDuty2 = 7'd75;
    localparam logic [DutyW-1:0] LightDuty3 = 7'd50;
    localparam logic [DutyW-1:0] LightDuty4 = 7'd25;

    // duty*255/100 equals duty*255*5243 >> 19 for every 7-bit duty.
    localparam int PwmShift = 19;
    localparam int PwmProdW = 28;
    localparam logic [PwmProdW-1:0] PwmRecip = PwmProdW'(255 * 5243);

    typedef struct packed {
        logic [PwCodesW-1:0] codes;
        logic [PwLenW-1:0]   length;
    } t_cfg;

    typedef struct packed {
        logic [PwmW-1:0]   cooler_pwm;
        logic [PwmW-1:0]   heater_pwm;
        logic [PwmW-1:0]   light_pwm;
        logic [AlarmW-1:0] alarm;
        logic              unlocked;
        logic              show_entry;
        logic [CountW-1:0] entry_count;
        logic [EventW-1:0] event_res;
    } t_result;

    // floor(x/5) for x below 64, by multiplying with 13/64.
    function automatic logic [3:0] div5(input logic [5:0] x);
        logic [9:0] prod;
        prod = 10'(x) * 10'd13;
        return prod[9:6];
    endfunction

    function automatic logic [PwmW-1:0] duty_to_pwm(input logic [DutyW-1:0] duty);
        logic [PwmProdW-1:0] prod;
        logic [PwmProdW-PwmShift-1:0] val;
        prod = PwmProdW'(duty) * PwmRecip;
        val  = prod[PwmProdW-1:PwmShift];
        return (val > (PwmProdW-PwmShift)'(255)) ? 8'hFF : val[PwmW-1:0];
    endfunction

endpackage
`default_nettype wire

### sv/klt_engine.sv
`default_nettype none
module klt_engine (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_fire,
    input  wire [7:0]             i_cmd_byte,
    input  wire klt_pkg::t_cfg    i_cfg,
    output klt_pkg::t_result      o_result
);
    import klt_pkg::*;

    logic                 r_unlocked, n_unlocked;
    logic                 r_show, n_show;
    logic [EntryCntW-1:0] r_len, n_len;
    logic [DutyW-1:0]     r_cooler, n_cooler;
    logic [DutyW-1:0]     r_heater, n_heater;
    logic [DutyW-1:0]     r_light, n_light;
    logic [AlarmW-1:0]    r_alarm, n_alarm;
    logic [CodeW-1:0]     r_entry [MaxEntry];

    logic [ByteW-1:0]     key_diff;
    logic [CodeW-1:0]     key_code;
    logic [ByteW-1:0]     level;
    logic [DutyW-1:0]     temp;
    logic [DutyW-1:0]     cool_diff;
    logic [3:0]           cool_q;
    logic [3:0]           heat_q;
    logic [PwLenW-1:0]    plen;
    logic                 pw_ok;
    logic                 wr_en;
    logic [EventW-1:0]    ev;

    assign key_diff  = i_cmd_byte - KeyBase;
    assign key_code  = key_diff[CodeW-1:0];
    assign level     = i_cmd_byte - TempLimit;
    assign temp      = i_cmd_byte[DutyW-1:0];
    assign cool_diff = temp - TempCoolLo;
    assign cool_q    = div5(cool_diff[5:0]);
    assign heat_q    = div5(temp[5:0]);

    // The entry must have the password length (up to 8) and match it slot by slot.
    always_comb begin
        plen  = (i_cfg.length > PwLenW'(MaxPassword)) ? PwLenW'(MaxPassword) : i_cfg.length;
        pw_ok = (r_len == EntryCntW'(plen));
        for (int i = 0; i < MaxPassword; i++) begin
            if ((PwLenW'(i) < plen) && (r_entry[i] != i_cfg.codes[i*CodeW +: CodeW])) begin
                pw_ok = 1'b0;
            end
        end
    end

    always_comb begin
        n_unlocked = r_unlocked;
        n_show     = r_show;
        n_len      = r_len;
        n_cooler   = r_cooler;
        n_heater   = r_heater;
        n_light    = r_light;
        n_alarm    = r_alarm;
        wr_en      = 1'b0;
        ev         = EvIgnored;
        if (i_cmd_byte >= KeyBase) begin
            if (!r_unlocked) begin
                unique case (key_code)
                    KeyEnter: begin
                        if (pw_ok) begin
                            n_unlocked = 1'b1;
                            n_len      = '0;
                            ev         = EvGranted;
                        end else begin
                            ev = EvWrong;
                        end
                    end
                    KeyErase: begin
                        if (r_len != '0) begin
                            n_len = r_len - EntryCntW'(1);
                            ev    = EvErased;
                        end
                    end
                    KeyToggle: begin
                        n_show = ~r_show;
                        ev     = EvToggled;
                    end
                    default: begin
                        if (r_len >= EntryCntW'(MaxEntry)) begin
                            ev = EvFull;
                        end else begin
                            wr_en = 1'b1;
                            n_len = r_len + EntryCntW'(1);
                            ev    = EvStored;
                        end
                    end
                endcase
            end
        end else if (i_cmd_byte > TempLimit) begin
            if (r_unlocked) begin
                priority if (level <= LightLvl1) begin
                    n_light = LightDuty1;
                end else if (level <= LightLvl2) begin
                    n_light = LightDuty2;
                end else if (level <= LightLvl3) begin
                    n_light = LightDuty3;
                end else begin
                    n_light = LightDuty4;
                end
                ev = EvLight;
            end
        end else if (i_cmd_byte < TempLimit) begin
            if (r_unlocked) begin
                // Temperatures between the heating and cooling bands keep the duties.
                if (temp >= TempCoolLo && temp <= TempCoolHi) begin
                    n_cooler = CoolBase + DutyW'(cool_q) * CoolStep;
                    n_heater = '0;
                end else if (temp >= TempHeatLo && temp <= TempHeatHi) begin
                    n_cooler = '0;
                    n_heater = HeatFull - DutyW'(heat_q) * HeatStep;
                end else if (temp > TempCoolHi || temp < TempHeatLo) begin
                    n_cooler = '0;
                    n_heater = '0;
                end
                priority if (temp > TempCoolHi) begin
                    n_alarm = AlarmHot;
                end else if (temp < TempHeatLo) begin
                    n_alarm = AlarmCold;
                end else begin
                    n_alarm = AlarmNone;
                end
                ev = EvTemp;
            end
        end
    end

    always_comb begin
        o_result.cooler_pwm  = duty_to_pwm(n_cooler);
        o_result.heater_pwm  = duty_to_pwm(n_heater);
        o_result.light_pwm   = duty_to_pwm(n_light);
        o_result.alarm       = n_alarm;
        o_result.unlocked    = n_unlocked;
        o_result.show_entry  = n_show;
        o_result.entry_count = CountW'(n_len);
        o_result.event_res   = ev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unlocked <= 1'b0;
            r_show     <= 1'b1;
            r_len      <= '0;
            r_cooler   <= '0;
            r_heater   <= '0;
            r_light    <= '0;
            r_alarm    <= AlarmNone;
        end else if (i_fire) begin
            r_unlocked <= n_unlocked;
            r_show     <= n_show;
            r_len      <= n_len;
            r_cooler   <= n_cooler;
            r_heater   <= n_heater;
            r_light    <= n_light;
            r_alarm    <= n_alarm;
        end
    end

    // Entries only affect results below the current length, so they need no reset.
    always_ff @(posedge i_clk) begin
        if (i_fire && wr_en) begin
            r_entry[r_len[EntryIdxW-1:0]] <= key_code;
        end
    end

endmodule
`default_nettype wire

### sv/keypad_lock_thermostat_top.sv
// Keypad lock and thermostat controller.
// Command bytes enter on the cmd channel (i_cmd_valid, o_cmd_ready, i_cmd_byte);
// every item produces exactly one result on the res channel (o_res_valid,
// i_res_ready and the o_* result fields), in order.
// An accepted item is held in an input register until the skid entry is free;
// the lock, thermostat and light logic then runs combinationally from it into
// the output register, or into the skid entry while the output is stalled.
// Throughput is one item per cycle while the receiver takes results.
// The output register is backed by one skid entry; when the receiver stalls,
// up to three items (input register, output, skid) are held before o_cmd_ready
// drops, and nothing is lost or repeated.
// The password registers sit on the APB port: password_codes at address 0x0,
// password_length at 0x8 (data 64 bits, low address bits ignored).
// A synchronous active-low reset locks the block, shows the entry in clear,
// empties the entry, zeroes all duties and the alarm and restores the default
// password; it also empties the input, output and skid registers.
`default_nettype none
module keypad_lock_thermostat_top (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cmd_valid,
    output logic                        o_cmd_ready,
    input  wire  [7:0]                  i_cmd_byte,
    output logic                        o_res_valid,
    input  wire                         i_res_ready,
    output logic [7:0]                  o_cooler_pwm,
    output logic [7:0]                  o_heater_pwm,
    output logic [7:0]                  o_light_pwm,
    output logic [1:0]                  o_alarm,
    output logic                        o_unlocked,
    output logic                        o_show_entry,
    output logic [4:0]                  o_entry_count,
    output logic [3:0]                  o_event_res,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire  [klt_pkg::ApbAddrW-1:0] paddr,
    input  wire  [klt_pkg::ApbDataW-1:0] pwdata,
    output logic [klt_pkg::ApbDataW-1:0] prdata,
    output logic                        pready
);
    import klt_pkg::*;

    `include "keypad_lock_thermostat_top_assert.svh"

    t_cfg             r_cfg;
    logic             r_in_valid, n_in_valid;
    logic [ByteW-1:0] r_cmd;
    logic             r_out_valid, n_out_valid;
    logic             r_skid_valid, n_skid_valid;
    t_result          r_out;
    t_result          r_skid;
    t_result          eng_result;

    logic fire;
    logic in_acc;
    logic out_pop;
    logic cfg_wr;
    logic load_out_eng;
    logic load_out_skid;
    logic load_skid;
    logic out_granted;
    logic out_cleared;
    logic out_count_ok;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.codes  <= PwCodesReset;
            r_cfg.length <= PwLenReset;
        end else if (cfg_wr) begin
            unique case (paddr[RegIdxBit])
                RegCodes:  r_cfg.codes  <= pwdata[PwCodesW-1:0];
                RegLength: r_cfg.length <= pwdata[PwLenW-1:0];
                default:   r_cfg        <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[RegIdxBit])
            RegCodes:  prdata = ApbDataW'(r_cfg.codes);
            RegLength: prdata = ApbDataW'(r_cfg.length);
            default:   prdata = '0;
        endcase
    end

    // The held item is processed whenever the skid entry is free to take
    // its result.
    assign fire        = r_in_valid && !r_skid_valid;
    assign o_cmd_ready = !r_in_valid || fire;
    assign in_acc      = i_cmd_valid && o_cmd_ready;
    assign out_pop     = r_out_valid && i_res_ready;

    klt_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_cmd_byte (r_cmd),
        .i_cfg      (r_cfg),
        .o_result   (eng_result)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_acc) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid   = r_out_valid;
        n_skid_valid  = r_skid_valid;
        load_out_eng  = 1'b0;
        load_out_skid = 1'b0;
        load_skid     = 1'b0;
        if (out_pop) begin
            n_out_valid = 1'b0;
        end
        if (r_skid_valid && out_pop) begin
            n_out_valid   = 1'b1;
            n_skid_valid  = 1'b0;
            load_out_skid = 1'b1;
        end
        if (fire) begin
            if (!r_out_valid || out_pop) begin
                n_out_valid  = 1'b1;
                load_out_eng = 1'b1;
            end else begin
                n_skid_valid = 1'b1;
                load_skid    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_in_valid   <= n_in_valid;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd <= i_cmd_byte;
        end
        if (load_out_eng) begin
            r_out <= eng_result;
        end else if (load_out_skid) begin
            r_out <= r_skid;
        end
        if (load_skid) begin
            r_skid <= eng_result;
        end
    end

    assign o_res_valid   = r_out_valid;
    assign o_cooler_pwm  = r_out.cooler_pwm;
    assign o_heater_pwm  = r_out.heater_pwm;
    assign o_light_pwm   = r_out.light_pwm;
    assign o_alarm       = r_out.alarm;
    assign o_unlocked    = r_out.unlocked;
    assign o_show_entry  = r_out.show_entry;
    assign o_entry_count = r_out.entry_count;
    assign o_event_res   = r_out.event_res;

    assign out_granted  = r_out_valid && (r_out.event_res == EvGranted);
    assign out_cleared  = r_out.unlocked && (r_out.entry_count == '0);
    assign out_count_ok = r_out.entry_count <= CountW'(MaxEntry);

    `KLT_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `KLT_ASSERT_NEXT(a_fire_fills_out, i_clk, i_rst_n, fire && !r_out_valid, r_out_valid)
    `KLT_ASSERT_NOW(a_grant_unlocks, i_clk, i_rst_n, out_granted, out_cleared)
    `KLT_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, r_out_valid, out_count_ok)

endmodule
`default_nettype wire
